>>> design/clwf_pkg.sv
// Shared types, constants and the microcode program for the character-LCD write formatter.
// Used by clwf_sequencer, clwf_datapath and char_lcd_write_formatter_core.
package clwf_pkg;

  // Operation codes of a request item
  typedef enum logic [1:0] {
    OP_INSTR  = 2'd0,
    OP_DATA   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_NUMBER = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  byte_value;
    logic        row;
    logic [5:0]  column;
    logic [31:0] number;
  } req_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_value;
    logic       last_transfer;
  } xfer_t;

  // Digit buffer sizing
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_SLOTS = 20;
  localparam int DIGIT_LIMIT = (MAX_DIGITS < 1) ? 1 :
                               ((MAX_DIGITS < DIGIT_SLOTS) ? MAX_DIGITS : DIGIT_SLOTS);
  localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
  localparam int IDX_W       = (DIGIT_LIMIT > 1) ? $clog2(DIGIT_LIMIT) : 1;

  localparam logic [7:0]  CURSOR_CMD    = 8'h80;
  localparam logic [6:0]  LINE_TWO_BASE = 7'h40;
  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
  localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT   = 35;

  // Datapath actions
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_MUL,
    ACT_DIGIT,
    ACT_POP,
    ACT_EMIT_HI,
    ACT_EMIT_LO,
    ACT_EMIT_FULL
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_IS_NUMBER,
    JC_EIGHT_BIT,
    JC_MORE_DIGITS,
    JC_DIGITS_LEFT
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program labels
  localparam step_t ST_ACCEPT = 4'd0;
  localparam step_t ST_BYTE   = 4'd1;
  localparam step_t ST_MUL    = 4'd2;
  localparam step_t ST_DIGIT  = 4'd3;
  localparam step_t ST_POP    = 4'd4;
  localparam step_t ST_SEND   = 4'd5;
  localparam step_t ST_HI     = 4'd6;
  localparam step_t ST_LO     = 4'd7;
  localparam step_t ST_FULL   = 4'd8;
  localparam step_t ST_CHECK  = 4'd9;
  localparam step_t ST_DONE   = 4'd10;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic req_valid;
    logic out_free;
    logic is_number;
    logic eight_bit;
    logic more_digits;
    logic digits_left;
  } dp_status_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '{act: ACT_NOP, cond: JC_ALWAYS, target: ST_ACCEPT};
    case (step)
      ST_ACCEPT: w = '{act: ACT_ACCEPT,    cond: JC_IS_NUMBER,   target: ST_MUL};
      ST_BYTE:   w = '{act: ACT_NOP,       cond: JC_ALWAYS,      target: ST_SEND};
      ST_MUL:    w = '{act: ACT_MUL,       cond: JC_NEVER,       target: ST_ACCEPT};
      ST_DIGIT:  w = '{act: ACT_DIGIT,     cond: JC_MORE_DIGITS, target: ST_MUL};
      ST_POP:    w = '{act: ACT_POP,       cond: JC_NEVER,       target: ST_ACCEPT};
      ST_SEND:   w = '{act: ACT_NOP,       cond: JC_EIGHT_BIT,   target: ST_FULL};
      ST_HI:     w = '{act: ACT_EMIT_HI,   cond: JC_NEVER,       target: ST_ACCEPT};
      ST_LO:     w = '{act: ACT_EMIT_LO,   cond: JC_ALWAYS,      target: ST_CHECK};
      ST_FULL:   w = '{act: ACT_EMIT_FULL, cond: JC_NEVER,       target: ST_ACCEPT};
      ST_CHECK:  w = '{act: ACT_NOP,       cond: JC_DIGITS_LEFT, target: ST_POP};
      ST_DONE:   w = '{act: ACT_NOP,       cond: JC_ALWAYS,      target: ST_ACCEPT};
      default:   w = '{act: ACT_NOP,       cond: JC_ALWAYS,      target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

>>> design/char_lcd_write_formatter_core.sv
// Top level of the character-LCD write formatter: mode register, sequencer and datapath.
// Depends on clwf_pkg, clwf_sequencer and clwf_datapath.
//
// Turns character-LCD requests into bus transfers, one result item per enable strobe.
// A request item carries an operation: instruction byte (register select 0), data
// character (register select 1), cursor move (instruction 0x80 OR the line address,
// second line based at 0x40), or a 32-bit unsigned number, sent as ASCII decimal digits
// most significant first (zero shows as a single '0'; only the lowest MAX_DIGITS digits
// are kept). With four_bit_mode set each byte leaves as two transfers, high nibble first,
// on bus bits 7..4 with bits 3..0 zero; otherwise each byte is one transfer. The last
// transfer of a request has last_transfer set. Write four_bit_mode through the cfg port
// only while the block is idle. The block works on one request at a time under a small
// microcode program and takes no new request until the last one is done; an emit step
// waits while the output is stalled. The digits come from a multiply-by-reciprocal
// divide-by-ten unit, two steps per digit (multiply, then quotient and remainder).
module char_lcd_write_formatter_core
  import clwf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  // request channel
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  // transfer channel
  output logic  xfer_valid,
  input  logic  xfer_stall,
  output xfer_t xfer,
  // mode register write
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  logic  cfg_data
);

  uword_t     uword;
  dp_status_t status;
  logic       four_bit_mode;

  // Mode writes taken out of reset; user must send them only while idle, not enforced
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      four_bit_mode <= cfg_data;
    end
  end

  // Take a request only in the accept step of the program, never during reset
  assign req_stall = rst || (uword.act != ACT_ACCEPT);

  clwf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  clwf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .uword         (uword),
    .four_bit_mode (four_bit_mode),
    .req_valid     (req_valid),
    .req           (req),
    .status        (status),
    .xfer_valid    (xfer_valid),
    .xfer_stall    (xfer_stall),
    .xfer          (xfer)
  );

endmodule

>>> design/clwf_sequencer.sv
// Step counter and microcode fetch for the character-LCD write formatter.
// Depends on clwf_pkg for the program, control word and status types.
module clwf_sequencer
  import clwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output uword_t     uword
);

  step_t step;
  step_t step_next;
  logic  hold;
  logic  taken;

  assign uword = ucode_rom(step);

  always_comb begin
    case (uword.act)
      ACT_ACCEPT:    hold = !status.req_valid;
      ACT_EMIT_HI,
      ACT_EMIT_LO,
      ACT_EMIT_FULL: hold = !status.out_free;
      default:       hold = 1'b0;
    endcase
  end

  always_comb begin
    case (uword.cond)
      JC_ALWAYS:      taken = 1'b1;
      JC_IS_NUMBER:   taken = status.is_number;
      JC_EIGHT_BIT:   taken = status.eight_bit;
      JC_MORE_DIGITS: taken = status.more_digits;
      JC_DIGITS_LEFT: taken = status.digits_left;
      default:        taken = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = uword.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> design/clwf_datapath.sv
// Datapath of the character-LCD write formatter: request latch, divide-by-ten unit,
// digit buffer and output register. Depends on clwf_pkg.
module clwf_datapath
  import clwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  uword_t     uword,
  input  logic       four_bit_mode,
  input  logic       req_valid,
  input  req_t       req,
  output dp_status_t status,
  output logic       xfer_valid,
  input  logic       xfer_stall,
  output xfer_t      xfer
);

  logic             rs;
  logic [7:0]       char_byte;
  logic             last_flag;
  logic [31:0]      value;
  logic [63:0]      prod;
  logic [CNT_W-1:0] cnt;
  logic [3:0]       digits [DIGIT_LIMIT];

  logic [31:0]      quot;
  logic [31:0]      rem_full;
  logic [CNT_W-1:0] cnt_dec;
  logic [7:0]       cursor_byte;
  logic             out_free;
  logic             emit;
  xfer_t            xfer_next;

  assign quot        = 32'(prod[63:RECIP_SHIFT]);
  assign rem_full    = value - ((quot << 3) + (quot << 1));
  assign cnt_dec     = cnt - CNT_W'(1);
  assign cursor_byte = CURSOR_CMD |
                       {1'b0, (req.row ? (LINE_TWO_BASE + {1'b0, req.column})
                                       : {1'b0, req.column})};
  assign out_free    = !xfer_valid || !xfer_stall;

  // The number test looks at the request being offered in the accept step
  assign status = '{
    req_valid:   req_valid,
    out_free:    out_free,
    is_number:   (req.operation == OP_NUMBER),
    eight_bit:   !four_bit_mode,
    more_digits: (quot != 32'd0) && ((cnt + CNT_W'(1)) < CNT_W'(DIGIT_LIMIT)),
    digits_left: (cnt != '0)
  };

  always_comb begin
    emit      = 1'b0;
    xfer_next = '{register_select: rs, bus_value: char_byte, last_transfer: last_flag};
    case (uword.act)
      ACT_EMIT_HI: begin
        emit      = 1'b1;
        xfer_next = '{register_select: rs, bus_value: {char_byte[7:4], 4'b0000},
                      last_transfer: 1'b0};
      end
      ACT_EMIT_LO: begin
        emit      = 1'b1;
        xfer_next = '{register_select: rs, bus_value: {char_byte[3:0], 4'b0000},
                      last_transfer: last_flag};
      end
      ACT_EMIT_FULL: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      xfer_valid <= 1'b0;
    end else begin
      case (uword.act)
        ACT_ACCEPT: begin
          if (req_valid) begin
            cnt       <= '0;
            last_flag <= 1'b1;
            value     <= req.number;
            case (req.operation)
              OP_INSTR: begin
                rs        <= 1'b0;
                char_byte <= req.byte_value;
              end
              OP_DATA: begin
                rs        <= 1'b1;
                char_byte <= req.byte_value;
              end
              OP_CURSOR: begin
                rs        <= 1'b0;
                char_byte <= cursor_byte;
              end
              default: begin
                rs        <= 1'b1;
                char_byte <= req.byte_value;
              end
            endcase
          end
        end
        ACT_MUL: begin
          prod <= value * RECIP_TEN;
        end
        ACT_DIGIT: begin
          digits[cnt[IDX_W-1:0]] <= rem_full[3:0];
          value                  <= quot;
          cnt                    <= cnt + CNT_W'(1);
        end
        ACT_POP: begin
          char_byte <= ASCII_ZERO + {4'b0000, digits[cnt_dec[IDX_W-1:0]]};
          last_flag <= (cnt == CNT_W'(1));
          cnt       <= cnt_dec;
        end
        default: begin
        end
      endcase

      // Hold the result until taken; load a new one whenever the slot frees
      if (emit && out_free) begin
        xfer_valid <= 1'b1;
        xfer       <= xfer_next;
      end else if (!xfer_stall) begin
        xfer_valid <= 1'b0;
      end
    end
  end

endmodule

>>> tb/char_lcd_write_formatter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking regression for char_lcd_write_formatter_core: directed table, then random requests.
// Depends on clwf_pkg for the request/transfer structs and op codes; predicts transfers locally.

module char_lcd_write_formatter_core_tb;
  import clwf_pkg::*;

  localparam int WATCHDOG_LIMIT    = 1000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int TAIL_CYCLES       = 80;
  localparam int ITEMS_PER_SEGMENT = 40;
  localparam int NUM_PROBES        = 20;
  // How many low-order decimal digits the block keeps
  localparam int DIGIT_CAP = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 20) ? 20 : MAX_DIGITS);
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] SECOND_LINE  = 8'h40;
  localparam logic [7:0] DIGIT_BASE   = 8'h30;

  // One directed row: mode to run it in, the request, and up to two hand-typed transfers
  typedef struct packed {
    logic       four_bit;
    req_t       r;
    logic [1:0] n_typed;
    xfer_t      t0;
    xfer_t      t1;
  } probe_t;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  xfer_valid;
  logic  xfer_stall;
  xfer_t xfer;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  xfer_t  pending_xfers [$];   // transfers still owed by the block, oldest first
  xfer_t  typed_xfers [2];     // hand-typed transfers for the directed row in flight
  int     typed_count;
  logic   mode_shadow;         // four_bit_mode as the block should hold it
  logic   mode_now;            // mode last written by the stimulus thread
  int     sender_idle_pct;
  int     receiver_stall_pct;
  int     fault_count;
  int     quiet_cycles;
  probe_t probes [NUM_PROBES];

  char_lcd_write_formatter_core u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .xfer_valid (xfer_valid),
    .xfer_stall (xfer_stall),
    .xfer       (xfer),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic xfer_t xf(logic rs, logic [7:0] bus, logic last);
    xfer_t t;
    t.register_select = rs;
    t.bus_value       = bus;
    t.last_transfer   = last;
    return t;
  endfunction

  function automatic probe_t probe(logic m, op_t op, logic [7:0] b, logic rw, logic [5:0] col,
                                   logic [31:0] num, logic [1:0] n, xfer_t t0, xfer_t t1);
    probe_t p;
    p.four_bit       = m;
    p.r.operation    = op;
    p.r.byte_value   = b;
    p.r.row          = rw;
    p.r.column       = col;
    p.r.number       = num;
    p.n_typed        = n;
    p.t0             = t0;
    p.t1             = t1;
    return p;
  endfunction

  // Queue one byte as the bus sees it: two nibble strobes, or one whole-byte strobe
  function automatic void queue_byte(logic nib, logic rs, logic [7:0] b, logic last);
    if (nib) begin
      pending_xfers.push_back(xf(rs, {b[7:4], 4'h0}, 1'b0));
      pending_xfers.push_back(xf(rs, {b[3:0], 4'h0}, last));
    end else begin
      pending_xfers.push_back(xf(rs, b, last));
    end
  endfunction

  // Work out every transfer that one request causes
  function automatic void predict_transfers(req_t r, logic nib);
    logic [3:0]  digit_buf [20];
    logic [31:0] v;
    logic [7:0]  addr;
    int          n;
    case (r.operation)
      OP_INSTR:  queue_byte(nib, 1'b0, r.byte_value, 1'b1);
      OP_DATA:   queue_byte(nib, 1'b1, r.byte_value, 1'b1);
      OP_CURSOR: begin
        addr = r.row ? (SECOND_LINE + r.column) : {2'b00, r.column};
        queue_byte(nib, 1'b0, SET_ADDR_CMD | addr, 1'b1);
      end
      OP_NUMBER: begin
        // Peel digits least significant first; zero still yields one digit
        v = r.number;
        n = 0;
        do begin
          digit_buf[n] = 4'(v % 10);
          n++;
          v = v / 10;
        end while (v != 0 && n < DIGIT_CAP);
        for (int i = n - 1; i >= 0; i--)
          queue_byte(nib, 1'b1, DIGIT_BASE + digit_buf[i], i == 0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic req_t random_request();
    req_t        r;
    logic [31:0] p;
    r.operation  = op_t'($urandom_range(3));
    r.byte_value = 8'($urandom);
    r.row        = 1'($urandom);
    r.column     = 6'($urandom);
    case ($urandom_range(7))
      0: r.number = '0;
      1: r.number = '1;
      2: r.number = $urandom_range(99);
      3: begin
        // Land on or just under a power of ten to flip the digit count
        p = 1;
        repeat ($urandom_range(9, 1)) p = p * 10;
        r.number = p - $urandom_range(1);
      end
      default: r.number = $urandom >> $urandom_range(31);
    endcase
    return r;
  endfunction

  // Present one request from a falling edge; return at the falling edge after it is taken
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop the request line and wait until the block owes nothing
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_xfers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  // Receiver: stall at the current rate, change only on falling edges
  always @(negedge clk) begin
    if (rst) begin
      xfer_stall <= 1'b0;
    end else begin
      xfer_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Scoreboard: track the mode, predict on each taken request, check each taken transfer
  always @(posedge clk) begin
    xfer_t want;
    if (rst) begin
      mode_shadow = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        mode_shadow = cfg_data;
      if (req_valid && !req_stall) begin
        if (typed_count != 0) begin
          pending_xfers.push_back(typed_xfers[0]);
          if (typed_count == 2)
            pending_xfers.push_back(typed_xfers[1]);
        end else begin
          predict_transfers(req, mode_shadow);
        end
      end
      if (xfer_valid && !xfer_stall) begin
        if (pending_xfers.size() == 0) begin
          $display("%0t: unexpected transfer rs=%0b bus=%02h last=%0b", $time,
                   xfer.register_select, xfer.bus_value, xfer.last_transfer);
          fault_count++;
        end else begin
          want = pending_xfers.pop_front();
          if (xfer.register_select !== want.register_select) begin
            $display("%0t: register_select expected %0b got %0b", $time,
                     want.register_select, xfer.register_select);
            fault_count++;
          end
          if (xfer.bus_value !== want.bus_value) begin
            $display("%0t: bus_value expected %02h got %02h", $time,
                     want.bus_value, xfer.bus_value);
            fault_count++;
          end
          if (xfer.last_transfer !== want.last_transfer) begin
            $display("%0t: last_transfer expected %0b got %0b", $time,
                     want.last_transfer, xfer.last_transfer);
            fault_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind completes for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (xfer_valid && !xfer_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_write_formatter_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    req_valid          = 1'b0;
    req                = '0;
    xfer_stall         = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    typed_count        = 0;
    fault_count        = 0;
    quiet_cycles       = 0;
    mode_now           = 1'b0;

    // Directed rows. Whole-byte mode first (reset value), then nibble mode.
    probes[0]  = probe(1'b0, OP_INSTR,  8'h00, 1'b0, 6'd0,  32'd0, 2'd1,
                       xf(1'b0, 8'h00, 1'b1), '0);
    probes[1]  = probe(1'b0, OP_INSTR,  8'hff, 1'b0, 6'd0,  32'd0, 2'd1,
                       xf(1'b0, 8'hff, 1'b1), '0);
    probes[2]  = probe(1'b0, OP_DATA,   8'h00, 1'b0, 6'd0,  32'd0, 2'd1,
                       xf(1'b1, 8'h00, 1'b1), '0);
    probes[3]  = probe(1'b0, OP_DATA,   8'hff, 1'b0, 6'd0,  32'd0, 2'd1,
                       xf(1'b1, 8'hff, 1'b1), '0);
    probes[4]  = probe(1'b0, OP_CURSOR, 8'h00, 1'b0, 6'd0,  32'd0, 2'd1,
                       xf(1'b0, 8'h80, 1'b1), '0);
    probes[5]  = probe(1'b0, OP_CURSOR, 8'h00, 1'b1, 6'd63, 32'd0, 2'd1,
                       xf(1'b0, 8'hff, 1'b1), '0);
    probes[6]  = probe(1'b0, OP_CURSOR, 8'hff, 1'b0, 6'd63, 32'hffff_ffff, 2'd1,
                       xf(1'b0, 8'hbf, 1'b1), '0);
    // Number zero shows a single '0'
    probes[7]  = probe(1'b0, OP_NUMBER, 8'hff, 1'b1, 6'd63, 32'd0, 2'd1,
                       xf(1'b1, 8'h30, 1'b1), '0);
    probes[8]  = probe(1'b0, OP_NUMBER, 8'h00, 1'b0, 6'd0,  32'hffff_ffff, 2'd0, '0, '0);
    probes[9]  = probe(1'b0, OP_NUMBER, 8'h00, 1'b0, 6'd0,  32'd9, 2'd1,
                       xf(1'b1, 8'h39, 1'b1), '0);
    probes[10] = probe(1'b0, OP_NUMBER, 8'h00, 1'b0, 6'd0,  32'd10, 2'd0, '0, '0);
    // Unused fields set to all ones must not leak into an instruction
    probes[11] = probe(1'b0, OP_INSTR,  8'h5a, 1'b1, 6'd63, 32'hffff_ffff, 2'd1,
                       xf(1'b0, 8'h5a, 1'b1), '0);
    probes[12] = probe(1'b1, OP_INSTR,  8'ha5, 1'b0, 6'd0,  32'd0, 2'd2,
                       xf(1'b0, 8'ha0, 1'b0), xf(1'b0, 8'h50, 1'b1));
    probes[13] = probe(1'b1, OP_DATA,   8'h3c, 1'b0, 6'd0,  32'd0, 2'd2,
                       xf(1'b1, 8'h30, 1'b0), xf(1'b1, 8'hc0, 1'b1));
    probes[14] = probe(1'b1, OP_CURSOR, 8'h00, 1'b1, 6'h15, 32'd0, 2'd2,
                       xf(1'b0, 8'hd0, 1'b0), xf(1'b0, 8'h50, 1'b1));
    probes[15] = probe(1'b1, OP_NUMBER, 8'h00, 1'b0, 6'd0,  32'd0, 2'd2,
                       xf(1'b1, 8'h30, 1'b0), xf(1'b1, 8'h00, 1'b1));
    probes[16] = probe(1'b1, OP_NUMBER, 8'hff, 1'b1, 6'd63, 32'hffff_ffff, 2'd0, '0, '0);
    probes[17] = probe(1'b1, OP_NUMBER, 8'h00, 1'b0, 6'd0,  32'd1_000_000_000, 2'd0, '0, '0);
    probes[18] = probe(1'b1, OP_DATA,   8'hff, 1'b1, 6'd63, 32'hffff_ffff, 2'd2,
                       xf(1'b1, 8'hf0, 1'b0), xf(1'b1, 8'hf0, 1'b1));
    probes[19] = probe(1'b1, OP_CURSOR, 8'h00, 1'b1, 6'd63, 32'd0, 2'd2,
                       xf(1'b0, 8'hf0, 1'b0), xf(1'b0, 8'hf0, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; switch mode only once the block has gone quiet
    for (int i = 0; i < NUM_PROBES; i++) begin
      if (probes[i].four_bit != mode_now) begin
        settle();
        write_mode(probes[i].four_bit);
      end
      typed_count    = probes[i].n_typed;
      typed_xfers[0] = probes[i].t0;
      typed_xfers[1] = probes[i].t1;
      send_request(probes[i].r);
    end
    typed_count = 0;

    // Random part: four idling phases, each run in both bus modes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
      endcase
      for (int m = 0; m < 2; m++) begin
        settle();
        write_mode(m[0]);
        repeat (ITEMS_PER_SEGMENT) send_request(random_request());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("char_lcd_write_formatter_core regression: pass");
    end else begin
      $display("char_lcd_write_formatter_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/clwf_pkg.sv
design/clwf_sequencer.sv
design/clwf_datapath.sv
design/char_lcd_write_formatter_core.sv
tb/char_lcd_write_formatter_core_tb.sv
